// ===== hw/rtl/rsvg_pkg.sv =====
// Shared constants, register map and sine table build functions for the ring sector generator.
package rsvg_pkg;

  localparam int unsigned REG_W  = 16;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned POS_W  = 17;
  localparam int unsigned TEX_W  = 22;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned MAG_W  = 15;

  // Q1.15 unity, also the cap for the hole ratio
  localparam logic [16:0] UNITY_Q15 = 17'h08000;

  // Register indexes (byte address bits [4:2])
  localparam logic [2:0] REG_OUTER_RADIUS = 3'd0;
  localparam logic [2:0] REG_HOLE_RATIO   = 3'd1;
  localparam logic [2:0] REG_START_ANGLE  = 3'd2;
  localparam logic [2:0] REG_ANGLE_STEP   = 3'd3;
  localparam logic [2:0] REG_TEX_LEFT     = 3'd4;
  localparam logic [2:0] REG_TEX_TOP      = 3'd5;
  localparam logic [2:0] REG_TEX_WIDTH    = 3'd6;
  localparam logic [2:0] REG_TEX_HEIGHT   = 3'd7;

  localparam logic [63:0] HALF_PI_Q62 =
    64'h6000000000000000 + (64'h243F6A8885A308D3 >> 3);

  // (a*b) >> 62 on unsigned Q62 operands; used at elaboration only
  function automatic logic [63:0] mul62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Divide a Taylor term by (2k)(2k+1)
  function automatic logic [63:0] taylor_div(input logic [63:0] t, input int unsigned k);
    logic [63:0] q;
    case (k)
      1:       q = t / 64'd6;
      2:       q = t / 64'd20;
      3:       q = t / 64'd42;
      4:       q = t / 64'd72;
      5:       q = t / 64'd110;
      6:       q = t / 64'd156;
      7:       q = t / 64'd210;
      8:       q = t / 64'd272;
      9:       q = t / 64'd342;
      10:      q = t / 64'd420;
      11:      q = t / 64'd506;
      12:      q = t / 64'd600;
      13:      q = t / 64'd702;
      default: q = t / 64'd812;
    endcase
    return q;
  endfunction

  function automatic logic [63:0] sin_q62(input logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] sum;
    logic [63:0] term;
    t2   = mul62(t, t);
    sum  = t;
    term = t;
    for (int unsigned k = 1; k <= 14; k++) begin
      term = taylor_div(mul62(term, t2), k);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // First-quadrant magnitude round(32767*sin) for step j of a 2^ab-step turn
  function automatic logic [MAG_W-1:0] sine_mag(input int unsigned j, input int unsigned ab);
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] v;
    x  = 64'(j) << (64 - ab);
    s  = sin_q62(mul62(HALF_PI_Q62, x));
    hi = s >> 31;
    lo = s & 64'h7FFFFFFF;
    v  = (64'd32767 * hi + ((64'd32767 * lo) >> 31) + (64'd1 << 30)) >> 31;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/rsvg_sine_rom.sv =====
// Quarter-wave sine magnitude table with two registered read ports.
module rsvg_sine_rom #(
  parameter int unsigned ANGLE_BITS = 12
) (
  input  logic                        clk,
  input  logic [ANGLE_BITS-2:0]       rd_addr_a,
  input  logic [ANGLE_BITS-2:0]       rd_addr_b,
  output logic [rsvg_pkg::MAG_W-1:0]  rd_data_a,
  output logic [rsvg_pkg::MAG_W-1:0]  rd_data_b
);

  localparam int unsigned QTR   = 1 << (ANGLE_BITS - 2);
  localparam int unsigned DEPTH = QTR + 1;

  logic [rsvg_pkg::MAG_W-1:0] rom [DEPTH];
  logic [rsvg_pkg::MAG_W-1:0] data_a_r;
  logic [rsvg_pkg::MAG_W-1:0] data_b_r;

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    assign rom[g] = rsvg_pkg::sine_mag(g, ANGLE_BITS);
  end

  // Addresses never exceed QTR: the caller folds the quadrant.
  always_ff @(posedge clk) begin
    data_a_r <= rom[rd_addr_a];
    data_b_r <= rom[rd_addr_b];
  end

  assign rd_data_a = data_a_r;
  assign rd_data_b = data_b_r;

endmodule

// ===== hw/rtl/ring_sector_vertex_generator_unit.sv =====
// Top level: ring sector triangle-strip vertex generator, five-stage pipeline.
//
//  channel  | handshake                         | words
//  ---------+-----------------------------------+----------------------------------
//  input    | start, busy (accept: start&!busy) | in_vertex_index
//  result   | out_valid strobe, one cycle       | out_pos_x/y, out_tex_u/v
//  config   | psel/penable/pwrite/pready (APB)  | paddr, pwdata, prdata
//
// One word enters per clock; busy is held low. Each result passes through the five
// registered stages after its input word is accepted: angle multiply-add,
// sine table read, scale multiply, radius/texture multiplies, final adds.
// Synchronous active-low reset clears the configuration registers and drops every valid bit
// in flight. The receiver takes every strobe, so nothing ever stalls.
module ring_sector_vertex_generator_unit #(
  parameter int unsigned ANGLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                start,
  output logic                                busy,
  input  logic [rsvg_pkg::IDX_W-1:0]          in_vertex_index,
  // result channel
  output logic                                out_valid,
  output logic [rsvg_pkg::POS_W-1:0]          out_pos_x,
  output logic [rsvg_pkg::POS_W-1:0]          out_pos_y,
  output logic signed [rsvg_pkg::TEX_W-1:0]   out_tex_u,
  output logic signed [rsvg_pkg::TEX_W-1:0]   out_tex_v,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rsvg_pkg::ADDR_W-1:0]         paddr,
  input  logic [rsvg_pkg::DATA_W-1:0]         pwdata,
  output logic [rsvg_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int unsigned QTR = 1 << (ANGLE_BITS - 2);
  localparam int unsigned TA_W = ANGLE_BITS - 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] cfg_outer_radius_r;
  logic [15:0] cfg_hole_ratio_r;
  logic [15:0] cfg_start_angle_r;
  logic [15:0] cfg_angle_step_r;
  logic [15:0] cfg_tex_left_r;
  logic [15:0] cfg_tex_top_r;
  logic [15:0] cfg_tex_width_r;
  logic [15:0] cfg_tex_height_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_outer_radius_r <= '0;
      cfg_hole_ratio_r   <= '0;
      cfg_start_angle_r  <= '0;
      cfg_angle_step_r   <= '0;
      cfg_tex_left_r     <= '0;
      cfg_tex_top_r      <= '0;
      cfg_tex_width_r    <= '0;
      cfg_tex_height_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rsvg_pkg::REG_OUTER_RADIUS: cfg_outer_radius_r <= pwdata[15:0];
        rsvg_pkg::REG_HOLE_RATIO:   cfg_hole_ratio_r   <= pwdata[15:0];
        rsvg_pkg::REG_START_ANGLE:  cfg_start_angle_r  <= pwdata[15:0];
        rsvg_pkg::REG_ANGLE_STEP:   cfg_angle_step_r   <= pwdata[15:0];
        rsvg_pkg::REG_TEX_LEFT:     cfg_tex_left_r     <= pwdata[15:0];
        rsvg_pkg::REG_TEX_TOP:      cfg_tex_top_r      <= pwdata[15:0];
        rsvg_pkg::REG_TEX_WIDTH:    cfg_tex_width_r    <= pwdata[15:0];
        rsvg_pkg::REG_TEX_HEIGHT:   cfg_tex_height_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the raw register words
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      rsvg_pkg::REG_OUTER_RADIUS: prdata = {16'd0, cfg_outer_radius_r};
      rsvg_pkg::REG_HOLE_RATIO:   prdata = {16'd0, cfg_hole_ratio_r};
      rsvg_pkg::REG_START_ANGLE:  prdata = {16'd0, cfg_start_angle_r};
      rsvg_pkg::REG_ANGLE_STEP:   prdata = {16'd0, cfg_angle_step_r};
      rsvg_pkg::REG_TEX_LEFT:     prdata = {16'd0, cfg_tex_left_r};
      rsvg_pkg::REG_TEX_TOP:      prdata = {16'd0, cfg_tex_top_r};
      rsvg_pkg::REG_TEX_WIDTH:    prdata = {16'd0, cfg_tex_width_r};
      rsvg_pkg::REG_TEX_HEIGHT:   prdata = {16'd0, cfg_tex_height_r};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage 1: angle = start + step * point (mod one turn)
  // ---------------------------------------------------------------------------
  logic        in_acc;
  logic        v1_r;
  logic [15:0] angle_r;
  logic [15:0] angle_nxt;
  logic        odd1_r;
  logic [10:0] point;

  assign busy   = 1'b0;
  assign in_acc = start && !busy;
  assign point  = in_vertex_index[11:1];
  assign angle_nxt = 16'(cfg_start_angle_r + 16'(cfg_angle_step_r * {5'd0, point}));

  always_ff @(posedge clk) begin
    if (in_acc) begin
      angle_r <= angle_nxt;
      odd1_r  <= in_vertex_index[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: fold quadrants and read sine and cosine magnitudes
  // ---------------------------------------------------------------------------
  logic [ANGLE_BITS-1:0] ti;
  logic [1:0]            q_sin;
  logic [1:0]            q_cos;
  logic [TA_W-1:0]       x_lo;
  logic [TA_W-1:0]       addr_sin;
  logic [TA_W-1:0]       addr_cos;
  logic                  v2_r;
  logic                  odd2_r;
  logic                  neg_sin2_r;
  logic                  neg_cos2_r;
  logic [rsvg_pkg::MAG_W-1:0] mag_sin;
  logic [rsvg_pkg::MAG_W-1:0] mag_cos;

  assign ti    = angle_r[15 -: ANGLE_BITS];
  assign q_sin = ti[ANGLE_BITS-1 -: 2];
  assign q_cos = q_sin + 2'd1;  // cosine sits a quarter turn ahead
  assign x_lo  = TA_W'(ti[ANGLE_BITS-3:0]);

  // Mirror the step inside odd quadrants
  assign addr_sin = q_sin[0] ? TA_W'(QTR) - x_lo : x_lo;
  assign addr_cos = q_cos[0] ? TA_W'(QTR) - x_lo : x_lo;

  rsvg_sine_rom #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_rom (
    .clk       (clk),
    .rd_addr_a (addr_sin),
    .rd_addr_b (addr_cos),
    .rd_data_a (mag_sin),
    .rd_data_b (mag_cos)
  );

  always_ff @(posedge clk) begin
    if (v1_r) begin
      odd2_r     <= odd1_r;
      neg_sin2_r <= q_sin[1];
      neg_cos2_r <= q_cos[1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: scale trig values by s (Q1.15): 32768 outer, saturated hole inner
  // ---------------------------------------------------------------------------
  logic signed [15:0] sn;
  logic signed [15:0] cs;
  logic [16:0]        hole_sat;
  logic [16:0]        scale;
  logic signed [33:0] ps_full;
  logic signed [33:0] pc_full;
  logic               v3_r;
  logic signed [30:0] ps_r;
  logic signed [30:0] pc_r;

  assign sn = neg_sin2_r ? -$signed({1'b0, mag_sin}) : $signed({1'b0, mag_sin});
  assign cs = neg_cos2_r ? -$signed({1'b0, mag_cos}) : $signed({1'b0, mag_cos});

  assign hole_sat = ({1'b0, cfg_hole_ratio_r} > rsvg_pkg::UNITY_Q15) ?
                    rsvg_pkg::UNITY_Q15 : {1'b0, cfg_hole_ratio_r};
  assign scale    = odd2_r ? hole_sat : rsvg_pkg::UNITY_Q15;

  assign ps_full = 34'(sn) * 34'($signed({1'b0, scale}));
  assign pc_full = 34'(cs) * 34'($signed({1'b0, scale}));

  // |trig * s| stays below 2^30
  always_ff @(posedge clk) begin
    if (v2_r) begin
      ps_r <= ps_full[30:0];
      pc_r <= pc_full[30:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: radius and texture extent products
  // ---------------------------------------------------------------------------
  logic [30:0]        wu;
  logic [30:0]        wv;
  logic               v4_r;
  logic signed [47:0] prx_r;
  logic signed [47:0] pry_r;
  logic [46:0]        pru_r;
  logic [46:0]        prv_r;

  // 2^30 + S*s and 2^30 - C*s are both positive and below 2^31
  assign wu = 31'(32'sh40000000 + 32'(ps_r));
  assign wv = 31'(32'sh40000000 - 32'(pc_r));

  always_ff @(posedge clk) begin
    if (v3_r) begin
      prx_r <= 48'(ps_r) * 48'($signed({1'b0, cfg_outer_radius_r}));
      pry_r <= 48'(pc_r) * 48'($signed({1'b0, cfg_outer_radius_r}));
      pru_r <= 47'(cfg_tex_width_r) * 47'(wu);
      prv_r <= 47'(cfg_tex_height_r) * 47'(wv);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: floor the products and add the offsets
  // ---------------------------------------------------------------------------
  logic [17:0]        x_sum;
  logic [17:0]        y_sum;
  logic [21:0]        u_sum;
  logic [21:0]        v_sum;
  logic               v5_r;
  logic [16:0]        pos_x_r;
  logic [16:0]        pos_y_r;
  logic [21:0]        tex_u_r;
  logic [21:0]        tex_v_r;

  // Drop the low 30 bits of two's complement products: that is the floor
  assign x_sum = {2'd0, cfg_outer_radius_r} + 18'(prx_r[47:30]);
  assign y_sum = {2'd0, cfg_outer_radius_r} - 18'(pry_r[47:30]);
  // 16 * extent * w / 2^31 is the product shifted by 27
  assign u_sum = {{2{cfg_tex_left_r[15]}}, cfg_tex_left_r, 4'd0} + {2'd0, pru_r[46:27]};
  assign v_sum = {{2{cfg_tex_top_r[15]}}, cfg_tex_top_r, 4'd0} + {2'd0, prv_r[46:27]};

  always_ff @(posedge clk) begin
    if (v4_r) begin
      pos_x_r <= x_sum[16:0];
      pos_y_r <= y_sum[16:0];
      tex_u_r <= u_sum;
      tex_v_r <= v_sum;
    end
  end

  // Advance valid bits along with the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;
  assign out_tex_u = $signed(tex_u_r);
  assign out_tex_v = $signed(tex_v_r);

endmodule

// ===== hw/rtl/rsvg_checker.sv =====
// Port-level checker for the ring sector generator and its bind.
module rsvg_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic pready
);

  // Every accepted word yields its result strobe
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("accepted word produced no result");

  // No strobe without an accepted word behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##5 !out_valid)
    else $error("result without accepted word");

  // No strobe right after reset releases
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

  // The block takes a word and a register access every cycle
  a_always_open: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && pready)
    else $error("block refused a word or an access");

endmodule

bind ring_sector_vertex_generator_unit rsvg_checker u_rsvg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .pready    (pready)
);
